// ===== rtl/lzbd_pkg.sv =====
// Shared types and constants for the byte-oriented LZ decompressor.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package lzbd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 7;
  localparam int unsigned CountW   = 2;
  localparam int unsigned HistAw   = 8;
  localparam int unsigned HistDepth = 1 << HistAw;

  localparam logic [ByteW-1:0] LenMask   = 8'h7f;
  localparam logic [ByteW-1:0] MatchFlag = 8'h80;

  localparam logic [CountW-1:0] CntNone = 2'd0;
  localparam logic [CountW-1:0] CntOne  = 2'd1;
  localparam logic [CountW-1:0] CntTwo  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_hdr;   // latch length from a non-zero header
    logic end_emit;   // present the stream-end result
    logic lit_emit;   // write literal to history and present it
    logic load_dist;  // latch the match distance
    logic rd_issue;   // read one history byte
    logic wr_byte;    // write the read byte back and pack it
    logic emit_pair;  // present the packed match result
  } lzbd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic byte_zero;  // in_byte is zero
    logic byte_match; // in_byte has the match flag
    logic rem_zero;   // no bytes owed
    logic rem_one;    // one byte owed
    logic half;       // one match byte is already packed
    logic out_free;   // output register can take a result this cycle
  } lzbd_sts_t;

endpackage

`default_nettype wire

// ===== rtl/lzbd_ctrl.sv =====
// Controller state machine for the LZ decompressor.
// Depends on lzbd_pkg for the command and status structs.
`default_nettype none

module lzbd_ctrl
  import lzbd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  lzbd_sts_t      sts_i,
  output lzbd_cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    S_HEADER  = 6'b000001,
    S_LITERAL = 6'b000010,
    S_DIST    = 6'b000100,
    S_RD      = 6'b001000,
    S_WR      = 6'b010000,
    S_EMIT    = 6'b100000
  } lzbd_state_e;

  lzbd_state_e state_q, state_d;
  logic        accept;

  assign in_ready_o = (state_q == S_HEADER || state_q == S_LITERAL || state_q == S_DIST)
                      && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_HEADER: begin
        if (accept) begin
          if (sts_i.byte_zero) begin
            cmd_o.end_emit = 1'b1;
          end else begin
            cmd_o.load_hdr = 1'b1;
            state_d = sts_i.byte_match ? S_DIST : S_LITERAL;
          end
        end
      end
      S_LITERAL: begin
        if (accept) begin
          cmd_o.lit_emit = 1'b1;
          if (sts_i.rem_one) state_d = S_HEADER;
        end
      end
      S_DIST: begin
        if (accept) begin
          cmd_o.load_dist = 1'b1;
          state_d = sts_i.rem_zero ? S_HEADER : S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d = S_WR;
      end
      S_WR: begin
        cmd_o.wr_byte = 1'b1;
        // pair complete, or this was the last byte owed
        state_d = (sts_i.half || sts_i.rem_one) ? S_EMIT : S_RD;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_pair = 1'b1;
          state_d = sts_i.rem_zero ? S_HEADER : S_RD;
        end
      end
      default: state_d = S_HEADER;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HEADER;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lzbd_dp.sv =====
// Datapath for the LZ decompressor: history ring, counters, packing and
// output register. Depends on lzbd_pkg; driven by lzbd_ctrl commands.
`default_nettype none

module lzbd_dp
  import lzbd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [ByteW-1:0]   in_byte_i,
  input  lzbd_cmd_t               cmd_i,
  output lzbd_sts_t               sts_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [ByteW-1:0]        out_first_o,
  output logic [ByteW-1:0]        out_second_o,
  output logic [CountW-1:0]       byte_count_o,
  output logic                    stream_end_o,
  output logic                    last_of_run_o
);

  logic [ByteW-1:0]  hist_mem [HistDepth];
  logic [HistAw-1:0] wp_q;
  logic [HistAw-1:0] dist_q;
  logic [ByteW-1:0]  rd_q;
  logic [LenW-1:0]   rem_q;
  logic              half_q;
  logic [ByteW-1:0]  first_q, second_q;

  logic              out_valid_q;
  logic [ByteW-1:0]  out_first_q, out_second_q;
  logic [CountW-1:0] out_cnt_q;
  logic              out_end_q, out_last_q;

  logic              wr_en;
  logic [ByteW-1:0]  wr_data;
  logic              load_out;

  assign sts_o.byte_zero  = (in_byte_i == '0);
  assign sts_o.byte_match = ((in_byte_i & MatchFlag) != '0);
  assign sts_o.rem_zero   = (rem_q == '0);
  assign sts_o.rem_one    = (rem_q == LenW'(1));
  assign sts_o.half       = half_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign wr_en    = cmd_i.lit_emit || cmd_i.wr_byte;
  assign wr_data  = cmd_i.lit_emit ? in_byte_i : rd_q;
  assign load_out = cmd_i.end_emit || cmd_i.lit_emit || cmd_i.emit_pair;

  // History ring: one write and one registered read per cycle, never cleared.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[wp_q] <= wr_data;
    end
    if (cmd_i.rd_issue) begin
      rd_q <= hist_mem[wp_q - dist_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rem_q  <= '0;
      half_q <= 1'b0;
    end else begin
      if (wr_en) wp_q <= wp_q + HistAw'(1);
      if (cmd_i.load_hdr) begin
        rem_q <= LenW'(in_byte_i & LenMask);
      end else if (cmd_i.end_emit) begin
        rem_q <= '0;
      end else if (wr_en) begin
        rem_q <= rem_q - LenW'(1);
      end
      if (cmd_i.emit_pair) begin
        half_q <= 1'b0;
      end else if (cmd_i.wr_byte) begin
        half_q <= !half_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_dist) dist_q <= in_byte_i;
    if (cmd_i.wr_byte) begin
      if (half_q) second_q <= rd_q;
      else        first_q  <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.end_emit) begin
      out_first_q  <= '0;
      out_second_q <= '0;
      out_cnt_q    <= CntNone;
      out_end_q    <= 1'b1;
      out_last_q   <= 1'b1;
    end else if (cmd_i.lit_emit) begin
      out_first_q  <= in_byte_i;
      out_second_q <= '0;
      out_cnt_q    <= CntOne;
      out_end_q    <= 1'b0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.emit_pair) begin
      // half still set means the final byte of an odd run stands alone
      out_first_q  <= first_q;
      out_second_q <= half_q ? '0 : second_q;
      out_cnt_q    <= half_q ? CntOne : CntTwo;
      out_end_q    <= 1'b0;
      out_last_q   <= (rem_q == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_first_o   = out_first_q;
  assign out_second_o  = out_second_q;
  assign byte_count_o  = out_cnt_q;
  assign stream_end_o  = out_end_q;
  assign last_of_run_o = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/lz_byte_decompressor.sv =====
// Top level of the byte-oriented LZ decompressor.
// Joins lzbd_ctrl and lzbd_dp; depends on lzbd_pkg.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------
//   in      | sink      | in_valid_i / in_ready_o   | in_byte_i
//   out     | source    | out_valid_o / out_ready_i | out_first_o, out_second_o,
//           |           |                        | byte_count_o, stream_end_o,
//           |           |                        | last_of_run_o
//
// Header, literal and distance bytes are each accepted while the output
// register is free. Each match byte is read from history (one registered
// memory read port) and written back; each result holds one or two of them.
// Reset clears the state machine, ring pointer and counters; the history ring
// is not cleared and needs no sweep. The input stalls during a match and
// whenever a result waits in the output register and is not taken.
`default_nettype none

module lz_byte_decompressor
  import lzbd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [ByteW-1:0]   in_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [ByteW-1:0]        out_first_o,
  output logic [ByteW-1:0]        out_second_o,
  output logic [CountW-1:0]       byte_count_o,
  output logic                    stream_end_o,
  output logic                    last_of_run_o
);

  lzbd_cmd_t cmd;
  lzbd_sts_t sts;

  lzbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lzbd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_byte_i     (in_byte_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_first_o   (out_first_o),
    .out_second_o  (out_second_o),
    .byte_count_o  (byte_count_o),
    .stream_end_o  (stream_end_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire

// ===== rtl/lzbd_checker.sv =====
// Port-level checks for lz_byte_decompressor, attached by bind.
// Depends on lzbd_pkg for field widths and count codes.
`default_nettype none

module lzbd_checker
  import lzbd_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [ByteW-1:0]  out_first_o,
  input wire logic [ByteW-1:0]  out_second_o,
  input wire logic [CountW-1:0] byte_count_o,
  input wire logic              stream_end_o,
  input wire logic              last_of_run_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_first_o)
      && $stable(out_second_o) && $stable(byte_count_o)
      && $stable(stream_end_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  // Never take input unless the output register can accept its result.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o || out_ready_i)
    else $error("input ready while output blocked");

  a_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_end_o |-> byte_count_o == CntNone && last_of_run_o
      && out_first_o == '0 && out_second_o == '0)
    else $error("malformed stream-end result");

  a_empty_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_count_o == CntNone |-> stream_end_o)
    else $error("empty result without stream end");

  a_second_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_count_o != CntTwo |-> out_second_o == '0
      && byte_count_o != 2'd3)
    else $error("second byte set on short result");

endmodule

bind lz_byte_decompressor lzbd_checker u_lzbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .out_first_o   (out_first_o),
  .out_second_o  (out_second_o),
  .byte_count_o  (byte_count_o),
  .stream_end_o  (stream_end_o),
  .last_of_run_o (last_of_run_o)
);

`default_nettype wire
